[rtl/gdr_pkg.sv]
// ----------------------------------------------------------------------------
// gdr_pkg: shared types and constants of the grid DDA raycaster
// Holds the item and result layouts, register indexes and arithmetic widths.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int MAP_SIDE_DEF  = 64;
  localparam int MAX_STEPS_DEF = 128;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // Divider operand widths and internal coordinate widths.
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 40;
  localparam int CRD_W  = 24;
  localparam int RAY_W  = 34;
  localparam int CAM_W  = 29;
  localparam int EDGE_W = 56;
  localparam int LINE_W = 21;

  localparam logic [31:0]       SAT32    = 32'hFFFF_FFFF;
  localparam logic [LINE_W-1:0] LINE_CAP = LINE_W'(1 << 20);

  // Configuration register indexes.
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_POS_X         = 3'd2;
  localparam logic [2:0] REG_POS_Y         = 3'd3;
  localparam logic [2:0] REG_DIR_X         = 3'd4;
  localparam logic [2:0] REG_DIR_Y         = 3'd5;
  localparam logic [2:0] REG_PLANE_X       = 3'd6;
  localparam logic [2:0] REG_PLANE_Y       = 3'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic        cell_wall;
    logic [11:0] column;
  } cmd_t;

  typedef struct packed {
    logic [11:0] column;
    logic [31:0] distance;
    logic [11:0] draw_start;
    logic [11:0] draw_end;
    logic        hit_side;
    logic [5:0]  hit_row;
    logic [5:0]  hit_col;
    logic        escaped;
  } res_t;

  typedef struct packed {
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } cfg_t;

endpackage

[rtl/gdr_ram.sv]
// ----------------------------------------------------------------------------
// gdr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/gdr_fifo.sv]
// ----------------------------------------------------------------------------
// gdr_fifo: small synchronous queue
// Register-based FIFO used between the front and back and at the output.
// ----------------------------------------------------------------------------
module gdr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

[rtl/gdr_div.sv]
// ----------------------------------------------------------------------------
// gdr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module gdr_div
  import gdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt, den_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
      quo_nxt = {quo_r[DIV_NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/gdr_back.sv]
// ----------------------------------------------------------------------------
// gdr_back: execution sequencer of the raycaster
// Applies cell writes to the wall map and runs the ray setup and DDA walk.
// ----------------------------------------------------------------------------
module gdr_back
  import gdr_pkg::*;
#(
  parameter int MAP_SIDE  = MAP_SIDE_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int AW    = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int NW    = $clog2(MAX_STEPS + 1);
  localparam int FX_W  = FRAC_BITS + 1;
  localparam int MUL_W = FX_W + 32;
  localparam int POS_W = 48;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CAM   = 15'b000000000000010,
    S_RMUL  = 15'b000000000000100,
    S_RSUM  = 15'b000000000001000,
    S_DX    = 15'b000000000010000,
    S_DY    = 15'b000000000100000,
    S_MULX  = 15'b000000001000000,
    S_MULY  = 15'b000000010000000,
    S_SFIN  = 15'b000000100000000,
    S_STEP  = 15'b000001000000000,
    S_READ  = 15'b000010000000000,
    S_CHECK = 15'b000100000000000,
    S_DIST  = 15'b001000000000000,
    S_LINE  = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic                    issued_r, issued_nxt;
  logic [11:0]             col_r, col_nxt;
  logic signed [CAM_W-1:0] cam_r, cam_nxt;
  logic signed [44:0]      prodx_r, prodx_nxt, prody_r, prody_nxt;
  logic signed [RAY_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [31:0]             dx_r, dx_nxt, dy_r, dy_nxt, sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic [MUL_W-1:0]        mul_r, mul_nxt;
  logic signed [CRD_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic                    side_r, side_nxt;
  logic [31:0]             dist_r, dist_nxt;
  res_t                    res_r, res_nxt;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic            ram_we, ram_re, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;

  logic [12:0]            sw_eff, sh_eff;
  logic [POS_W-1:0]       posx_ext, posy_ext;
  logic [FX_W-1:0]        fx, fy;
  logic [RAY_W-1:0]       rx_mag, ry_mag;
  logic [32:0]            sdx_add, sdy_add;
  logic signed [EDGE_W-1:0] edge_pos, diff;
  logic [EDGE_W-1:0]      diff_mag;
  logic [MUL_W-FRAC_BITS-1:0] mul_sh;
  logic                   out_of_map;
  logic [LINE_W-2:0]      line_half;
  logic signed [LINE_W+1:0] span_lo, span_hi;
  logic [LINE_W-1:0]      line_val;

  gdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  gdr_ram #(
    .WIDTH (1),
    .DEPTH (MAP_SIDE * MAP_SIDE)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.cell_wall),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sw_eff   = (cfg.screen_width == '0) ? 13'd1 : cfg.screen_width;
  assign sh_eff   = (cfg.screen_height == '0) ? 13'd1 :
                    (cfg.screen_height > 13'd4096) ? 13'd4096 : cfg.screen_height;
  assign posx_ext = POS_W'(cfg.pos_x);
  assign posy_ext = POS_W'(cfg.pos_y);

  // Distance from the viewer to the first grid line along each axis.
  assign fx = rx_r[RAY_W-1] ? FX_W'(posx_ext[FRAC_BITS-1:0])
                            : FX_W'(1 << FRAC_BITS) - FX_W'(posx_ext[FRAC_BITS-1:0]);
  assign fy = ry_r[RAY_W-1] ? FX_W'(posy_ext[FRAC_BITS-1:0])
                            : FX_W'(1 << FRAC_BITS) - FX_W'(posy_ext[FRAC_BITS-1:0]);

  assign rx_mag = rx_r[RAY_W-1] ? RAY_W'(-rx_r) : RAY_W'(rx_r);
  assign ry_mag = ry_r[RAY_W-1] ? RAY_W'(-ry_r) : RAY_W'(ry_r);

  assign sdx_add = {1'b0, sdx_r} + {1'b0, dx_r};
  assign sdy_add = {1'b0, sdy_r} + {1'b0, dy_r};
  assign mul_sh  = mul_r[MUL_W-1:FRAC_BITS];

  assign out_of_map = mx_r[CRD_W-1] || my_r[CRD_W-1] ||
                      (mx_r >= signed'(CRD_W'(MAP_SIDE))) ||
                      (my_r >= signed'(CRD_W'(MAP_SIDE)));

  // Grid line that was crossed: the near edge of the hit cell.
  always_comb begin
    if (side_r) begin
      edge_pos = (EDGE_W'(my_r) + EDGE_W'(ry_r[RAY_W-1])) <<< FRAC_BITS;
      diff     = edge_pos - signed'(EDGE_W'(posy_ext));
    end else begin
      edge_pos = (EDGE_W'(mx_r) + EDGE_W'(rx_r[RAY_W-1])) <<< FRAC_BITS;
      diff     = edge_pos - signed'(EDGE_W'(posx_ext));
    end
    diff_mag = diff[EDGE_W-1] ? EDGE_W'(-diff) : EDGE_W'(diff);
  end

  assign line_val  = (div_quo > DIV_NW'(LINE_CAP)) ? LINE_CAP : LINE_W'(div_quo);
  assign line_half = line_val[LINE_W-1:1];
  assign span_lo   = signed'((LINE_W+2)'(sh_eff[12:1])) - signed'((LINE_W+2)'(line_half));
  assign span_hi   = signed'((LINE_W+2)'(sh_eff[12:1])) + signed'((LINE_W+2)'(line_half));

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    col_nxt    = col_r;
    cam_nxt    = cam_r;
    prodx_nxt  = prodx_r;
    prody_nxt  = prody_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    sdx_nxt    = sdx_r;
    sdy_nxt    = sdy_r;
    mul_nxt    = mul_r;
    mx_nxt     = mx_r;
    my_nxt     = my_r;
    n_nxt      = n_r;
    side_nxt   = side_r;
    dist_nxt   = dist_r;
    res_nxt    = res_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(cmd.cell_row) * AW'(MAP_SIDE) + AW'(cmd.cell_col);
    ram_re     = 1'b0;
    ram_raddr  = AW'(unsigned'(my_r)) * AW'(MAP_SIDE) + AW'(unsigned'(mx_r));

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.operation == OP_WRITE) begin
            ram_we = (32'(cmd.cell_row) < 32'(MAP_SIDE)) &&
                     (32'(cmd.cell_col) < 32'(MAP_SIDE));
          end else begin
            col_nxt   = cmd.column;
            state_nxt = S_CAM;
          end
        end
      end
      S_CAM: begin
        div_num = DIV_NW'({col_r, 15'b0});
        div_den = DIV_DW'(sw_eff);
        if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          cam_nxt    = signed'(CAM_W'(div_quo[26:0])) - CAM_W'(16384);
          state_nxt  = S_RMUL;
        end
      end
      S_RMUL: begin
        prodx_nxt = cfg.plane_x * cam_r;
        prody_nxt = cfg.plane_y * cam_r;
        state_nxt = S_RSUM;
      end
      S_RSUM: begin
        rx_nxt    = RAY_W'(cfg.dir_x) + RAY_W'(prodx_r >>> 14);
        ry_nxt    = RAY_W'(cfg.dir_y) + RAY_W'(prody_r >>> 14);
        state_nxt = S_DX;
      end
      S_DX: begin
        div_num = DIV_NW'(1) << (14 + FRAC_BITS);
        div_den = DIV_DW'(rx_mag);
        if (rx_r == '0) begin
          dx_nxt    = SAT32;
          state_nxt = S_DY;
        end else if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          dx_nxt     = (div_quo[DIV_NW-1:32] != '0) ? SAT32 : div_quo[31:0];
          state_nxt  = S_DY;
        end
      end
      S_DY: begin
        div_num = DIV_NW'(1) << (14 + FRAC_BITS);
        div_den = DIV_DW'(ry_mag);
        if (ry_r == '0) begin
          dy_nxt    = SAT32;
          state_nxt = S_MULX;
        end else if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          dy_nxt     = (div_quo[DIV_NW-1:32] != '0) ? SAT32 : div_quo[31:0];
          state_nxt  = S_MULX;
        end
      end
      S_MULX: begin
        mul_nxt   = MUL_W'(fx) * MUL_W'(dx_r);
        mx_nxt    = CRD_W'(posx_ext >> FRAC_BITS);
        my_nxt    = CRD_W'(posy_ext >> FRAC_BITS);
        state_nxt = S_MULY;
      end
      S_MULY: begin
        sdx_nxt   = mul_sh[MUL_W-FRAC_BITS-1] ? SAT32 : mul_sh[31:0];
        mul_nxt   = MUL_W'(fy) * MUL_W'(dy_r);
        state_nxt = S_SFIN;
      end
      S_SFIN: begin
        sdy_nxt   = mul_sh[MUL_W-FRAC_BITS-1] ? SAT32 : mul_sh[31:0];
        n_nxt     = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // Ties step along y.
        if (sdx_r < sdy_r) begin
          sdx_nxt  = sdx_add[32] ? SAT32 : sdx_add[31:0];
          mx_nxt   = rx_r[RAY_W-1] ? mx_r - 1'b1 : mx_r + 1'b1;
          side_nxt = 1'b0;
        end else begin
          sdy_nxt  = sdy_add[32] ? SAT32 : sdy_add[31:0];
          my_nxt   = ry_r[RAY_W-1] ? my_r - 1'b1 : my_r + 1'b1;
          side_nxt = 1'b1;
        end
        n_nxt     = n_r + 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (out_of_map) begin
          res_nxt         = '0;
          res_nxt.column  = col_r;
          res_nxt.distance = SAT32;
          res_nxt.escaped = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ram_rdata) begin
          state_nxt = S_DIST;
        end else if (n_r == NW'(MAX_STEPS)) begin
          res_nxt          = '0;
          res_nxt.column   = col_r;
          res_nxt.distance = SAT32;
          res_nxt.escaped  = 1'b1;
          state_nxt        = S_EMIT;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_DIST: begin
        div_num = DIV_NW'(diff_mag) << 14;
        div_den = side_r ? DIV_DW'(ry_mag) : DIV_DW'(rx_mag);
        if ((side_r ? ry_r : rx_r) == '0) begin
          dist_nxt  = SAT32;
          state_nxt = S_LINE;
        end else if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          dist_nxt   = (div_quo[DIV_NW-1:32] != '0) ? SAT32 : div_quo[31:0];
          state_nxt  = S_LINE;
        end
      end
      S_LINE: begin
        div_num = DIV_NW'(sh_eff) << FRAC_BITS;
        div_den = DIV_DW'(dist_r);
        res_nxt.column   = col_r;
        res_nxt.distance = dist_r;
        res_nxt.hit_side = side_r;
        res_nxt.hit_row  = my_r[5:0];
        res_nxt.hit_col  = mx_r[5:0];
        res_nxt.escaped  = 1'b0;
        if (dist_r == '0) begin
          // The line is the cap, so the span covers the whole height.
          res_nxt.draw_start = 12'd0;
          res_nxt.draw_end   = 12'(sh_eff - 13'd1);
          state_nxt          = S_EMIT;
        end else if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          res_nxt.draw_start = span_lo[LINE_W+1] ? 12'd0 : 12'(span_lo);
          res_nxt.draw_end   = (span_hi > signed'((LINE_W+2)'(sh_eff - 13'd1))) ?
                               12'(sh_eff - 13'd1) : 12'(span_hi);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    cam_r   <= cam_nxt;
    prodx_r <= prodx_nxt;
    prody_r <= prody_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    sdx_r   <= sdx_nxt;
    sdy_r   <= sdy_nxt;
    mul_r   <= mul_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    n_r     <= n_nxt;
    side_r  <= side_nxt;
    dist_r  <= dist_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

[rtl/grid_dda_raycaster.sv]
// ----------------------------------------------------------------------------
// grid_dda_raycaster: DDA wall raycaster over a square bit grid
//
// Items enter through a queue-style port: a transaction is taken at a clock
// edge where in_push is high and in_full is low. A write item sets one map
// cell and produces no result; a cast item produces exactly one result.
// Results leave through a second queue: the oldest result sits on the out_
// ports while out_empty is low and is taken when out_pop is high.
// Configuration registers are written through cfg_valid/cfg_ready, which is
// always ready; write them only while the block is idle.
// A cast item runs five passes of the shared one-bit-per-cycle divider
// (camera position, two reciprocals, distance and line height), and the walk
// reads the map RAM once per step. A zero ray component skips its divider
// pass, and a ray that escapes skips the last two passes.
// Items are buffered in a four-entry queue ahead of the sequencer, so the
// input keeps accepting while a cast runs; two finished results can wait.
// When the receiver stalls, the sequencer holds its finished result and
// the input queue fills, then in_full rises. Reset empties both queues and
// restores the register defaults; the map holds no defined contents until
// its cells are written.
// ----------------------------------------------------------------------------
module grid_dda_raycaster
  import gdr_pkg::*;
#(
  parameter int MAP_SIDE  = MAP_SIDE_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Item channel.
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_operation,
  input  logic [5:0]  in_cell_row,
  input  logic [5:0]  in_cell_col,
  input  logic        in_cell_wall,
  input  logic [11:0] in_column,
  // Result channel.
  output logic        out_empty,
  input  logic        out_pop,
  output logic [11:0] out_column,
  output logic [31:0] out_distance,
  output logic [11:0] out_draw_start,
  output logic [11:0] out_draw_end,
  output logic        out_hit_side,
  output logic [5:0]  out_hit_row,
  output logic [5:0]  out_hit_col,
  output logic        out_escaped,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t in_cmd, cmd_head;
  res_t res_in, res_head;
  logic cmd_empty, cmd_pop, res_full, res_push;

  assign cfg_ready = 1'b1;

  // Register file: one register per index, upper data bits ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_data[12:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_data[12:0];
        REG_POS_X:         cfg_nxt.pos_x         = cfg_data;
        REG_POS_Y:         cfg_nxt.pos_y         = cfg_data;
        REG_DIR_X:         cfg_nxt.dir_x         = cfg_data[15:0];
        REG_DIR_Y:         cfg_nxt.dir_y         = cfg_data[15:0];
        REG_PLANE_X:       cfg_nxt.plane_x       = cfg_data[15:0];
        REG_PLANE_Y:       cfg_nxt.plane_y       = cfg_data[15:0];
        default:           cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 13'd640;
      cfg_r.screen_height <= 13'd480;
      cfg_r.pos_x         <= 22'd2097152;
      cfg_r.pos_y         <= 22'd2097152;
      cfg_r.dir_x         <= -16'sd16384;
      cfg_r.dir_y         <= 16'sd0;
      cfg_r.plane_x       <= 16'sd0;
      cfg_r.plane_y       <= 16'sd10813;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: every item is queued in arrival order, writes and casts alike,
  // so a cast always sees the map writes that were accepted before it.
  assign in_cmd.operation = in_operation;
  assign in_cmd.cell_row  = in_cell_row;
  assign in_cmd.cell_col  = in_cell_col;
  assign in_cmd.cell_wall = in_cell_wall;
  assign in_cmd.column    = in_column;

  gdr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (in_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  // Back: the sequencer decodes each item and carries it out.
  gdr_back #(
    .MAP_SIDE  (MAP_SIDE),
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  gdr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty)
  );

  assign out_column     = res_head.column;
  assign out_distance   = res_head.distance;
  assign out_draw_start = res_head.draw_start;
  assign out_draw_end   = res_head.draw_end;
  assign out_hit_side   = res_head.hit_side;
  assign out_hit_row    = res_head.hit_row;
  assign out_hit_col    = res_head.hit_col;
  assign out_escaped    = res_head.escaped;

endmodule

[dv/tb_grid_dda_raycaster.sv]
// ----------------------------------------------------------------------------
// tb_grid_dda_raycaster: self-checking testbench of the grid DDA raycaster
// Loads wall maps, casts rays under several camera settings and compares
// every result with an in-bench fixed-point ray tracer, field by field.
// ----------------------------------------------------------------------------
module tb_grid_dda_raycaster
  import gdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  GRID       = 64;
  localparam int  STEP_LIMIT = 128;
  localparam int  FRAC       = 16;
  localparam int  MAP_REACH  = 2;     // half side of the square of written cells
  localparam int  SETTLE     = 1000;  // longer than one full cast with a long walk
  localparam longint SAT     = 64'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_operation = OP_WRITE;
  logic [5:0]  in_cell_row = '0;
  logic [5:0]  in_cell_col = '0;
  logic        in_cell_wall = 1'b0;
  logic [11:0] in_column = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [11:0] out_column;
  logic [31:0] out_distance;
  logic [11:0] out_draw_start;
  logic [11:0] out_draw_end;
  logic        out_hit_side;
  logic [5:0]  out_hit_row;
  logic [5:0]  out_hit_col;
  logic        out_escaped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_SCREEN_WIDTH;
  logic [21:0] cfg_data = '0;

  grid_dda_raycaster DUT (.*);

  // Items waiting to be sent, and the ray results the block still owes us.
  cmd_t pending_items[$];
  res_t owed_hits[$];
  logic item_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   error_count = 0;

  // Shadow of the block's state: its wall grid and its camera registers.
  bit   wall_bits[GRID][GRID];
  cfg_t view;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint sat32(longint v);
    return (v > SAT) ? SAT : v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Reciprocal of a ray component in Q.FRAC; a zero component saturates.
  function automatic longint inv_delta(longint r);
    if (r == 0) return SAT;
    return sat32((longint'(1) << (14 + FRAC)) / magnitude(r));
  endfunction

  // Traces one screen column through the shadow grid and returns the
  // result the block is expected to produce for it.
  function automatic res_t trace_column(logic [11:0] col);
    longint sw, sh, cam, rx, ry, mx, my, stx, sty, px, py;
    longint dx, dy, fx, fy, sdx, sdy, edge_pos, p, r, wall_dist, line_h, top, bot;
    bit     hit;
    bit     side;
    res_t   res;
    sw = (view.screen_width == 0) ? 1 : longint'(view.screen_width);
    sh = (view.screen_height == 0) ? 1 : longint'(view.screen_height);
    if (sh > 4096) sh = 4096;
    px = longint'(view.pos_x);
    py = longint'(view.pos_y);
    cam = ((2 * longint'(col)) << 14) / sw - 16384;
    // Arithmetic right shift on a signed value is a floor division.
    rx = longint'(view.dir_x) + ((longint'(view.plane_x) * cam) >>> 14);
    ry = longint'(view.dir_y) + ((longint'(view.plane_y) * cam) >>> 14);
    mx = px >> FRAC;
    my = py >> FRAC;
    dx = inv_delta(rx);
    dy = inv_delta(ry);
    if (rx < 0) begin
      stx = -1;
      fx = px - (mx << FRAC);
    end else begin
      stx = 1;
      fx = ((mx + 1) << FRAC) - px;
    end
    if (ry < 0) begin
      sty = -1;
      fy = py - (my << FRAC);
    end else begin
      sty = 1;
      fy = ((my + 1) << FRAC) - py;
    end
    sdx = sat32((fx * dx) >> FRAC);
    sdy = sat32((fy * dy) >> FRAC);
    hit = 0;
    side = 0;
    // The viewer's own cell is skipped; ties between the axes step in y.
    for (int n = 0; n < STEP_LIMIT; n++) begin
      if (sdx < sdy) begin
        sdx = sat32(sdx + dx);
        mx += stx;
        side = 0;
      end else begin
        sdy = sat32(sdy + dy);
        my += sty;
        side = 1;
      end
      if (mx < 0 || my < 0 || mx >= GRID || my >= GRID) break;
      if (wall_bits[my][mx]) begin
        hit = 1;
        break;
      end
    end
    res = '0;
    res.column = col;
    if (!hit) begin
      res.distance = SAT32;
      res.escaped = 1'b1;
      return res;
    end
    if (side == 0) begin
      edge_pos = (mx + ((stx < 0) ? 1 : 0)) << FRAC;
      p = px;
      r = rx;
    end else begin
      edge_pos = (my + ((sty < 0) ? 1 : 0)) << FRAC;
      p = py;
      r = ry;
    end
    wall_dist = (r == 0) ? SAT : sat32((magnitude(edge_pos - p) << 14) / magnitude(r));
    line_h = (wall_dist != 0) ? (sh << FRAC) / wall_dist : (longint'(1) << 20);
    if (line_h > (longint'(1) << 20)) line_h = longint'(1) << 20;
    top = sh / 2 - line_h / 2;
    bot = line_h / 2 + sh / 2;
    if (top < 0) top = 0;
    if (bot > sh - 1) bot = sh - 1;
    res.distance   = wall_dist[31:0];
    res.draw_start = top[11:0];
    res.draw_end   = bot[11:0];
    res.hit_side   = side;
    res.hit_row    = my[5:0];
    res.hit_col    = mx[5:0];
    return res;
  endfunction

  // Reset and the idle gaps of both sides are decided at the falling edge,
  // so the block sees stable inputs at each rising edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      out_pop <= 1'b0;
    end else begin
      if (!in_push || item_taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push      <= 1'b1;
          in_operation <= pending_items[0].operation;
          in_cell_row  <= pending_items[0].cell_row;
          in_cell_col  <= pending_items[0].cell_col;
          in_cell_wall <= pending_items[0].cell_wall;
          in_column    <= pending_items[0].column;
        end else begin
          in_push <= 1'b0;
        end
      end
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Accepted items update the shadow grid or queue an expected result.
  always @(posedge clk) begin
    cmd_t item;
    item_taken <= rst_n && in_push && !in_full;
    if (rst_n && in_push && !in_full) begin
      item = pending_items.pop_front();
      if (item.operation == OP_WRITE)
        wall_bits[item.cell_row][item.cell_col] = item.cell_wall;
      else
        owed_hits.push_back(trace_column(item.column));
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Every popped result is matched against the oldest owed one.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (owed_hits.size() == 0) begin
        $error("result transaction for column %0d with none expected", out_column);
        error_count++;
      end else begin
        want = owed_hits.pop_front();
        check_field("out_column", want.column, out_column);
        check_field("out_distance", want.distance, out_distance);
        check_field("out_draw_start", want.draw_start, out_draw_start);
        check_field("out_draw_end", want.draw_end, out_draw_end);
        check_field("out_hit_side", want.hit_side, out_hit_side);
        check_field("out_hit_row", want.hit_row, out_hit_row);
        check_field("out_hit_col", want.hit_col, out_hit_col);
        check_field("out_escaped", want.escaped, out_escaped);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [21:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:  view.screen_width  = value[12:0];
      REG_SCREEN_HEIGHT: view.screen_height = value[12:0];
      REG_POS_X:         view.pos_x         = value;
      REG_POS_Y:         view.pos_y         = value;
      REG_DIR_X:         view.dir_x         = value[15:0];
      REG_DIR_Y:         view.dir_y         = value[15:0];
      REG_PLANE_X:       view.plane_x       = value[15:0];
      REG_PLANE_Y:       view.plane_y       = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_view(int w, int h, int px, int py, int dx, int dy, int plx, int ply);
    write_reg(REG_SCREEN_WIDTH, 22'(w));
    write_reg(REG_SCREEN_HEIGHT, 22'(h));
    write_reg(REG_POS_X, 22'(px));
    write_reg(REG_POS_Y, 22'(py));
    write_reg(REG_DIR_X, 22'(dx[15:0]));
    write_reg(REG_DIR_Y, 22'(dy[15:0]));
    write_reg(REG_PLANE_X, 22'(plx[15:0]));
    write_reg(REG_PLANE_Y, 22'(ply[15:0]));
  endtask

  function automatic void add_write(int row, int col, bit wall);
    cmd_t item;
    item = '0;
    item.operation = OP_WRITE;
    item.cell_row  = 6'(row);
    item.cell_col  = 6'(col);
    item.cell_wall = wall;
    pending_items.push_back(item);
  endfunction

  function automatic void add_cast(int col);
    cmd_t item;
    item = '0;
    item.operation = OP_CAST;
    item.column    = 12'(col);
    // The unused write fields still toggle so every input bit moves.
    item.cell_row  = 6'($urandom);
    item.cell_col  = 6'($urandom);
    item.cell_wall = 1'($urandom);
    pending_items.push_back(item);
  endfunction

  // Writes the square of cells around the viewer's cell, clipped to the map,
  // and walls its outer ring. A walk moves one cell at a time, so it stops at
  // the ring or leaves the map before it can reach a cell that was never set.
  function automatic void load_map(int cr, int cc, int density);
    for (int r = cr - MAP_REACH; r <= cr + MAP_REACH; r++)
      for (int c = cc - MAP_REACH; c <= cc + MAP_REACH; c++)
        if (r >= 0 && c >= 0 && r < GRID && c < GRID)
          add_write(r, c, ($urandom_range(99) < density) ||
                    (r == cr - MAP_REACH || r == cr + MAP_REACH ||
                     c == cc - MAP_REACH || c == cc + MAP_REACH));
  endfunction

  // Lets the block finish every item and owe nothing before a register write.
  task automatic drain();
    while (pending_items.size() != 0 || in_push || owed_hits.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int w;
    int density;
    int cr, cc, lo_r, hi_r, lo_c, hi_c;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 8; phase++) begin
      // Idle pattern rotates: sender gaps with heavy receiver stalls,
      // then the reverse, then both sides running flat out.
      case (phase % 3)
        0: begin send_idle_pct = 16; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      case (phase)
        // Default camera in the middle of the map.
        0: set_view(640, 480, 2097152, 2097152, -16384, 0, 0, 10813);
        // Zero width and zero height, viewer in the corner, extreme vectors.
        1: set_view(0, 0, 0, 0, 32767, 32767, -32768, 32767);
        // Widest screen, height above the limit, viewer at the far corner.
        2: set_view(4096, 8191, 4194303, 4194303, -32768, -32768, 32767, 0);
        // Flat ray along x: zero y component, and a wall right at the edge.
        3: set_view(320, 200, 32 << 16, (32 << 16) + 32768, -16384, 0, 0, 0);
        default: set_view($urandom_range(1, 4096), $urandom_range(1, 4096),
                          $urandom_range(1 << 16, 63 << 16),
                          $urandom_range(1 << 16, 63 << 16),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase

      // Viewers near the map edge have part of the ring outside the map,
      // so their rays can leave the map.
      cr = int'(view.pos_y >> FRAC);
      cc = int'(view.pos_x >> FRAC);
      lo_r = (cr - MAP_REACH + 1 < 0) ? 0 : cr - MAP_REACH + 1;
      hi_r = (cr + MAP_REACH - 1 > GRID - 1) ? GRID - 1 : cr + MAP_REACH - 1;
      lo_c = (cc - MAP_REACH + 1 < 0) ? 0 : cc - MAP_REACH + 1;
      hi_c = (cc + MAP_REACH - 1 > GRID - 1) ? GRID - 1 : cc + MAP_REACH - 1;
      density = $urandom_range(3, 30);
      load_map(cr, cc, density);
      if (phase == 3) add_write(32, 31, 1'b1);  // viewer stands on its edge

      w = (view.screen_width == 0) ? 1 : int'(view.screen_width);
      add_cast(0);
      add_cast(w - 1);
      add_cast(w / 2);
      add_cast(4095);

      for (int i = 0; i < 30; i++) begin
        // Later writes stay inside the ring so it stays closed.
        if ($urandom_range(99) < 25)
          add_write($urandom_range(lo_r, hi_r), $urandom_range(lo_c, hi_c),
                    $urandom_range(99) < density);
        else if ($urandom_range(99) < 80)
          add_cast($urandom_range(0, w - 1));
        else
          add_cast($urandom_range(0, 4095));
      end
      drain();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[grid_dda_raycaster.f]
rtl/gdr_pkg.sv
rtl/gdr_ram.sv
rtl/gdr_fifo.sv
rtl/gdr_div.sv
rtl/gdr_back.sv
rtl/grid_dda_raycaster.sv
dv/tb_grid_dda_raycaster.sv
